/* design/glob_wm_pkg.sv */
// Shared types and constants for the glob wildcard matcher.
// No dependencies; imported by the store, step and top-level modules.
package glob_wm_pkg;

  localparam int MAX_PATTERN_DEFAULT = 64;
  localparam logic [7:0] STAR_CHAR = 8'h2A;

  typedef enum logic {
    CMD_PATTERN = 1'b0,
    CMD_NAME    = 1'b1
  } cmd_e;

  typedef struct packed {
    logic       load;
    logic [7:0] char_value;
    logic       last_char;
  } load_req_t;

endpackage

/* design/glob_wildcard_matcher.sv */
// Glob wildcard matcher top level: input register, pattern store, step logic
// and result register. Depends on glob_wm_pkg, glob_wm_store, glob_wm_step.
// Throughput: one byte per cycle while no finished name waits on a stalled output.
// Result: a last name byte passes the input register, then the result register,
// and waits in the input register while an earlier result sits on a stalled output.
// Reset: empty closed pattern, no overflow, start position only; no words held.
module glob_wildcard_matcher import glob_wm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] char_value_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       matched_o,
  output logic       pattern_too_long_o
);

  localparam int LenW = $clog2(MAX_PATTERN + 1);
  localparam logic [MAX_PATTERN:0] StartVec = (MAX_PATTERN + 1)'(1);

  logic                     s1_valid_q, s1_valid_d;
  cmd_e                     s1_cmd_q;
  logic [7:0]               s1_char_q;
  logic                     s1_last_q;
  logic                     s1_emits, s1_fire, in_take, out_free;
  logic                     out_valid_q, out_valid_d;
  logic                     matched_q, too_long_q;
  logic [MAX_PATTERN:0]     active_q, active_d;
  logic [MAX_PATTERN*8-1:0] pattern_w;
  logic [LenW-1:0]          len_w;
  logic                     ovf_w;
  logic [MAX_PATTERN:0]     lead_w, lead_next_w, next_w;
  load_req_t                load;

  assign s1_emits   = (s1_cmd_q == CMD_NAME) & s1_last_q;
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign s1_fire    = s1_valid_q & (~s1_emits | out_free);
  assign in_stall_o = s1_valid_q & ~s1_fire;
  assign in_take    = in_valid_i & ~in_stall_o;
  assign s1_valid_d = in_take | (s1_valid_q & ~s1_fire);
  assign out_valid_d = (s1_fire & s1_emits) | (out_valid_q & out_stall_i);

  assign load.load       = s1_fire & (s1_cmd_q == CMD_PATTERN);
  assign load.char_value = s1_char_q;
  assign load.last_char  = s1_last_q;

  glob_wm_store #(.MAX_PATTERN(MAX_PATTERN)) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .pattern_o   (pattern_w),
    .len_o       (len_w),
    .overflow_o  (ovf_w),
    .lead_o      (lead_w),
    .lead_next_o (lead_next_w)
  );

  glob_wm_step #(.MAX_PATTERN(MAX_PATTERN)) u_step (
    .pattern_i    (pattern_w),
    .len_i        (len_w),
    .active_i     (active_q),
    .char_value_i (s1_char_q),
    .next_o       (next_w)
  );

  always_comb begin
    active_d = active_q;
    if (s1_fire) begin
      if (s1_cmd_q == CMD_PATTERN) begin
        active_d = lead_next_w;
      end else if (s1_last_q) begin
        active_d = lead_w;
      end else begin
        active_d = next_w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      active_q    <= StartVec;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      active_q    <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_cmd_q  <= cmd_e'(command_i);
      s1_char_q <= char_value_i;
      s1_last_q <= last_char_i;
    end
    if (s1_fire & s1_emits) begin
      matched_q  <= next_w[len_w] & ~ovf_w;
      too_long_q <= ovf_w;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign matched_o          = matched_q;
  assign pattern_too_long_o = too_long_q;

  a_no_match_on_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pattern_too_long_o |-> !matched_o)
    else $error("match reported on overflowed pattern");

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("stall raised with empty input register");

  a_active_within_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((active_q >> len_w) >> 1) == '0)
    else $error("active position beyond pattern end");

  a_restart_after_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_emits |=> active_q == lead_w)
    else $error("active vector not restarted after finished name");

  a_start_reachable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lead_w[0])
    else $error("start position missing from start vector");

endmodule

/* design/glob_wm_step.sv */
// Next-position logic for one candidate byte: literal hops, star self-loops
// and star closure done as a carry chain. Depends on glob_wm_pkg.
module glob_wm_step import glob_wm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
  localparam int LenW = $clog2(MAX_PATTERN + 1)
) (
  input  logic [MAX_PATTERN*8-1:0] pattern_i,
  input  logic [LenW-1:0]          len_i,
  input  logic [MAX_PATTERN:0]     active_i,
  input  logic [7:0]               char_value_i,
  output logic [MAX_PATTERN:0]     next_o
);

  logic [MAX_PATTERN-1:0] star_mask;
  logic [MAX_PATTERN:0]   hop;
  logic [MAX_PATTERN:0]   star_ext;
  logic [MAX_PATTERN:0]   stepped;
  logic [MAX_PATTERN:0]   gen;
  logic [MAX_PATTERN:0]   sum;
  logic [MAX_PATTERN:0]   carry;

  always_comb begin
    hop = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      logic       in_use;
      logic       is_star;
      logic [7:0] pat;
      pat          = pattern_i[i*8 +: 8];
      in_use       = LenW'(i) < len_i;
      is_star      = pat == STAR_CHAR;
      star_mask[i] = in_use & is_star;
      hop[i+1]     = active_i[i] & in_use & ~is_star & (pat == char_value_i);
    end
  end

  // carry into bit i+1 = star at i reached either directly or through carry
  assign star_ext = {1'b0, star_mask};
  assign stepped  = (active_i & star_ext) | hop;
  assign gen      = stepped & star_ext;
  assign sum      = star_ext + gen;
  assign carry    = sum ^ star_ext ^ gen;
  assign next_o   = stepped | carry;

endmodule

/* design/glob_wm_store.sv */
// Pattern store: byte registers, length, overflow, open/closed state and the
// leading-star start vector. Depends on glob_wm_pkg.
module glob_wm_store import glob_wm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEFAULT,
  localparam int LenW = $clog2(MAX_PATTERN + 1),
  localparam int IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  load_req_t                load_i,
  output logic [MAX_PATTERN*8-1:0] pattern_o,
  output logic [LenW-1:0]          len_o,
  output logic                     overflow_o,
  output logic [MAX_PATTERN:0]     lead_o,
  output logic [MAX_PATTERN:0]     lead_next_o
);

  localparam logic [MAX_PATTERN:0] StartVec = (MAX_PATTERN + 1)'(1);

  logic [7:0]           pat_q [MAX_PATTERN];
  logic [LenW-1:0]      len_q, len_d, base_len;
  logic                 ovf_q, ovf_d, base_ovf;
  logic                 closed_q, closed_d;
  logic [MAX_PATTERN:0] lead_q, lead_d, base_lead;
  logic                 room;
  logic                 is_star;
  logic                 we;

  always_comb begin
    base_len  = closed_q ? '0 : len_q;
    base_ovf  = closed_q ? 1'b0 : ovf_q;
    base_lead = closed_q ? StartVec : lead_q;
    room      = base_len < LenW'(MAX_PATTERN);
    is_star   = load_i.char_value == STAR_CHAR;
    len_d     = len_q;
    ovf_d     = ovf_q;
    closed_d  = closed_q;
    lead_d    = lead_q;
    we        = 1'b0;
    if (load_i.load) begin
      closed_d = load_i.last_char;
      len_d    = base_len;
      ovf_d    = base_ovf;
      lead_d   = base_lead;
      if (room) begin
        we    = 1'b1;
        len_d = base_len + LenW'(1);
        for (int i = 0; i < MAX_PATTERN; i++) begin
          if (LenW'(i) == base_len) begin
            lead_d[i+1] = base_lead[i] & is_star;
          end
        end
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      ovf_q    <= 1'b0;
      closed_q <= 1'b1;
      lead_q   <= StartVec;
    end else begin
      len_q    <= len_d;
      ovf_q    <= ovf_d;
      closed_q <= closed_d;
      lead_q   <= lead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      pat_q[base_len[IdxW-1:0]] <= load_i.char_value;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      pattern_o[i*8 +: 8] = pat_q[i];
    end
  end

  assign len_o       = len_q;
  assign overflow_o  = ovf_q;
  assign lead_o      = lead_q;
  assign lead_next_o = lead_d;

endmodule
